/* hdl/ordered_timer_queue_macros.svh */
// Assertion macros shared by the timer queue RTL.
`ifndef ORDERED_TIMER_QUEUE_MACROS_SVH
`define ORDERED_TIMER_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/otq_pkg.sv */
package otq_pkg;

  // Default number of timer slots in the ring.
  localparam int TimerSlotsDefault = 16;

  // Reset value of the minimum reload delay register.
  localparam logic [19:0] MinDelayReset = 20'd100;

  // Saturation value of a 63-bit time.
  localparam logic [62:0] TimeMax = {63{1'b1}};

  // Item kinds.
  localparam logic KindAdd    = 1'b0;
  localparam logic KindExpiry = 1'b1;

  // Contents of one timer slot as it travels round the ring.
  typedef struct packed {
    logic        valid;
    logic        due;
    logic        done;
    logic [62:0] exp;
    logic [47:0] ivl;
    logic [15:0] hnd;
  } slot_t;

endpackage

/* hdl/ordered_timer_queue.sv */
// A stored add makes a scan pass and a write pass before its status word, a refused add the
// scan pass alone, and an expiry word one selection pass per expired timer, each followed by
// its report, then a last selection pass and a re-arm pass; output hold-off can stall any word.
// One word at a time; every pass rotates the slot ring once round.
// Reset (rst_n low, synchronous): all slots empty, control idle, no result
// pending, min_delay_us back to 100.
`include "ordered_timer_queue_macros.svh"

module ordered_timer_queue import otq_pkg::*; #(
  parameter int TIMER_SLOTS = TimerSlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [62:0] in_now_us,
  input  logic [62:0] in_when_us,
  input  logic [47:0] in_interval_us,
  input  logic [15:0] in_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_expiry_report,
  output logic [15:0] out_expired_handle,
  output logic        out_earliest_changed,
  output logic        out_table_full,
  output logic        out_has_pending,
  output logic [62:0] out_next_expiration_us,
  output logic [62:0] out_reload_delay_us,
  output logic        out_last
);

  localparam int IdW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_SCAN, S_ADD_WRITE, S_EXP_SEL, S_EXP_EMIT, S_REARM,
    S_STAT_CALC, S_STAT_OUT
  } state_t;

  state_t         state_r;
  logic [IdW-1:0] cnt_r;
  logic [62:0]    now_r, when_r;
  logic [47:0]    ivl_r;
  logic [15:0]    hnd_r;
  logic           free_found_r;
  logic [IdW-1:0] free_id_r;
  logic           min_found_r;
  logic [62:0]    min_exp_r;
  logic           best_found_r;
  logic [IdW-1:0] best_id_r;
  logic [62:0]    best_exp_r;
  logic [15:0]    best_hnd_r;
  logic           sel_pend_r;
  logic [IdW-1:0] sel_id_r;
  logic           stat_chg_r, stat_full_r, stat_pend_r;
  logic [62:0]    stat_nxt_r;
  logic [62:0]    diff_r;
  logic [19:0]    min_delay_r;

  logic           out_valid_r, out_rep_r, out_chg_r, out_full_r, out_pend_r, out_last_r;
  logic [15:0]    out_hnd_r;
  logic [62:0]    out_nxt_r, out_dly_r;

  slot_t          slot_q [TIMER_SLOTS];
  logic [IdW-1:0] id_q   [TIMER_SLOTS];
  slot_t          fb;
  slot_t          head;
  logic [IdW-1:0] head_id;
  logic           shift_en, mark_en, pass_end, out_free;
  logic           sel_hit, cand, better, add_chg;
  logic [63:0]    sum64, sub64;
  logic [62:0]    rearm_exp, dly_raw;

  // Ring of slot cells; the head cell feeds the controller, which feeds the tail.
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    slot_t          nb_slot;
    logic [IdW-1:0] nb_id;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign nb_slot = fb;
      assign nb_id   = head_id;
    end else begin : g_mid
      assign nb_slot = slot_q[i+1];
      assign nb_id   = id_q[i+1];
    end
    otq_cell #(.IdW(IdW), .CELL_ID(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .mark_en  (mark_en),
      .now_us   (in_now_us),
      .slot_in  (nb_slot),
      .id_in    (nb_id),
      .slot_out (slot_q[i]),
      .id_out   (id_q[i])
    );
  end

  assign head     = slot_q[0];
  assign head_id  = id_q[0];
  assign in_ready = (state_r == S_IDLE);
  assign mark_en  = in_valid && in_ready && (in_kind == KindExpiry);
  assign pass_end = (cnt_r == IdW'(TIMER_SLOTS - 1));
  assign out_free = !out_valid_r || out_ready;

  // Re-armed expiration, saturating at the largest time.
  assign sum64     = {1'b0, now_r} + {16'd0, head.ivl};
  assign rearm_exp = sum64[63] ? TimeMax : sum64[62:0];

  // Selection of the next expired timer: by time, ties to the lower slot.
  assign sel_hit = sel_pend_r && (head_id == sel_id_r);
  assign cand    = head.due && !head.done && !sel_hit;
  assign better  = !best_found_r || (head.exp < best_exp_r) ||
                   ((head.exp == best_exp_r) && (head_id < best_id_r));
  assign add_chg = !min_found_r || (when_r < min_exp_r);

  // Delay to the next expiration; a borrow means it is already past.
  assign sub64   = {1'b0, stat_nxt_r} - {1'b0, now_r};
  assign dly_raw = (diff_r < {43'd0, min_delay_r}) ? {43'd0, min_delay_r} : diff_r;

  // Slot written back at the tail during each pass.
  always_comb begin
    fb       = head;
    shift_en = 1'b0;
    case (state_r)
      S_ADD_SCAN: begin
        shift_en = 1'b1;
      end
      S_ADD_WRITE: begin
        shift_en = 1'b1;
        if (head_id == free_id_r) begin
          fb.valid = 1'b1;
          fb.due   = 1'b0;
          fb.done  = 1'b0;
          fb.exp   = when_r;
          fb.ivl   = ivl_r;
          fb.hnd   = hnd_r;
        end
      end
      S_EXP_SEL: begin
        shift_en = 1'b1;
        if (sel_hit) begin
          fb.done = 1'b1;
        end
      end
      S_REARM: begin
        shift_en = 1'b1;
        if (head.due) begin
          if (head.ivl == 48'd0) begin
            fb.valid = 1'b0;
          end else begin
            fb.exp = rearm_exp;
          end
        end
        fb.due  = 1'b0;
        fb.done = 1'b0;
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  // Minimum delay register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_delay_r <= MinDelayReset;
    end else if (cfg_we) begin
      min_delay_r <= cfg_wdata;
    end
  end

  // Controller: state, pass bookkeeping and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      free_found_r <= 1'b0;
      min_found_r  <= 1'b0;
      best_found_r <= 1'b0;
      sel_pend_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (shift_en) begin
        cnt_r <= pass_end ? '0 : cnt_r + 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            now_r        <= in_now_us;
            when_r       <= in_when_us;
            ivl_r        <= in_interval_us;
            hnd_r        <= in_handle;
            cnt_r        <= '0;
            free_found_r <= 1'b0;
            min_found_r  <= 1'b0;
            best_found_r <= 1'b0;
            sel_pend_r   <= 1'b0;
            state_r      <= (in_kind == KindAdd) ? S_ADD_SCAN : S_EXP_SEL;
          end
        end
        S_ADD_SCAN: begin
          if (!head.valid && (!free_found_r || head_id < free_id_r)) begin
            free_found_r <= 1'b1;
            free_id_r    <= head_id;
          end
          if (head.valid && (!min_found_r || head.exp < min_exp_r)) begin
            min_found_r <= 1'b1;
            min_exp_r   <= head.exp;
          end
          if (pass_end) begin
            state_r <= S_STAT_CALC;
            // The last slot seen is folded in here as well.
            if (free_found_r || !head.valid) begin
              stat_chg_r  <= !head.valid ? add_chg && (min_found_r || 1'b1) &&
                             (!min_found_r || when_r < min_exp_r) &&
                             1'b1 : add_chg && (when_r < head.exp);
              stat_full_r <= 1'b0;
              stat_pend_r <= 1'b1;
              state_r     <= S_ADD_WRITE;
              if (!head.valid && !free_found_r) begin
                free_id_r <= head_id;
              end
              if (head.valid && (!min_found_r || head.exp < min_exp_r)) begin
                stat_nxt_r <= (when_r < head.exp) ? when_r : head.exp;
              end else begin
                stat_nxt_r <= add_chg ? when_r : min_exp_r;
              end
            end else begin
              stat_chg_r  <= 1'b0;
              stat_full_r <= 1'b1;
              stat_pend_r <= 1'b1;
              stat_nxt_r  <= (!min_found_r || head.exp < min_exp_r) ? head.exp : min_exp_r;
            end
          end
        end
        S_ADD_WRITE: begin
          if (pass_end) begin
            state_r <= S_STAT_CALC;
          end
        end
        S_EXP_SEL: begin
          if (cand && better) begin
            best_found_r <= 1'b1;
            best_id_r    <= head_id;
            best_exp_r   <= head.exp;
            best_hnd_r   <= head.hnd;
          end
          if (pass_end) begin
            if (best_found_r || cand) begin
              state_r <= S_EXP_EMIT;
            end else begin
              state_r <= S_REARM;
            end
          end
        end
        S_EXP_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_rep_r    <= 1'b1;
            out_hnd_r    <= best_hnd_r;
            out_chg_r    <= 1'b0;
            out_full_r   <= 1'b0;
            out_pend_r   <= 1'b0;
            out_nxt_r    <= '0;
            out_dly_r    <= '0;
            out_last_r   <= 1'b0;
            sel_pend_r   <= 1'b1;
            sel_id_r     <= best_id_r;
            best_found_r <= 1'b0;
            state_r      <= S_EXP_SEL;
          end
        end
        S_REARM: begin
          if (fb.valid && (!min_found_r || fb.exp < min_exp_r)) begin
            min_found_r <= 1'b1;
            min_exp_r   <= fb.exp;
          end
          if (pass_end) begin
            stat_chg_r  <= 1'b0;
            stat_full_r <= 1'b0;
            if (fb.valid && (!min_found_r || fb.exp < min_exp_r)) begin
              stat_pend_r <= 1'b1;
              stat_nxt_r  <= fb.exp;
            end else begin
              stat_pend_r <= min_found_r;
              stat_nxt_r  <= min_exp_r;
            end
            state_r <= S_STAT_CALC;
          end
        end
        S_STAT_CALC: begin
          diff_r  <= sub64[63] ? '0 : sub64[62:0];
          state_r <= S_STAT_OUT;
        end
        S_STAT_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rep_r   <= 1'b0;
            out_hnd_r   <= '0;
            out_chg_r   <= stat_chg_r;
            out_full_r  <= stat_full_r;
            out_pend_r  <= stat_pend_r;
            out_nxt_r   <= stat_pend_r ? stat_nxt_r : '0;
            out_dly_r   <= stat_pend_r ? dly_raw : '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_is_expiry_report   = out_rep_r;
  assign out_expired_handle     = out_hnd_r;
  assign out_earliest_changed   = out_chg_r;
  assign out_table_full         = out_full_r;
  assign out_has_pending        = out_pend_r;
  assign out_next_expiration_us = out_nxt_r;
  assign out_reload_delay_us    = out_dly_r;
  assign out_last               = out_last_r;

  // A refused add leaves the table full, so something is always pending.
  `OTQ_ASSERT_SAME(a_full_pending, out_valid && out_table_full,
    out_has_pending && !out_earliest_changed, "refused add reported wrong status")
  // An expiry report never closes an item.
  `OTQ_ASSERT_SAME(a_report_not_last, out_valid && out_is_expiry_report,
    !out_last, "expiry report marked as last")
  // Once a word is taken the block is busy in the next cycle.
  `OTQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input taken while busy")

endmodule

/* hdl/otq_cell.sv */
module otq_cell import otq_pkg::*; #(
  parameter int IdW     = 4,
  parameter int CELL_ID = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           mark_en,
  input  logic [62:0]    now_us,
  input  slot_t          slot_in,
  input  logic [IdW-1:0] id_in,
  output slot_t          slot_out,
  output logic [IdW-1:0] id_out
);

  slot_t          slot_r;
  logic [IdW-1:0] id_r;

  // The cell takes its neighbour's slot on a shift; on an expiry word it
  // flags itself as due when its timer has run out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
      slot_r.due   <= 1'b0;
      slot_r.done  <= 1'b0;
      id_r         <= IdW'(CELL_ID);
    end else if (shift_en) begin
      slot_r <= slot_in;
      id_r   <= id_in;
    end else if (mark_en) begin
      slot_r.due  <= slot_r.valid && (slot_r.exp <= now_us);
      slot_r.done <= 1'b0;
    end
  end

  assign slot_out = slot_r;
  assign id_out   = id_r;

endmodule

/* test/testbench.sv */
module testbench import otq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TimerSlotsDefault;
  localparam int STALL_LIMIT = 6000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [19:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [62:0] in_now_us;
  logic [62:0] in_when_us;
  logic [47:0] in_interval_us;
  logic [15:0] in_handle;
  logic        out_valid;
  logic        out_ready;
  logic        out_is_expiry_report;
  logic [15:0] out_expired_handle;
  logic        out_earliest_changed;
  logic        out_table_full;
  logic        out_has_pending;
  logic [62:0] out_next_expiration_us;
  logic [62:0] out_reload_delay_us;
  logic        out_last;

  ordered_timer_queue dut (.*);

  // One expected result word.
  typedef struct {
    logic        report;
    logic [15:0] hnd;
    logic        changed;
    logic        full;
    logic        pending;
    logic [62:0] next_exp;
    logic [62:0] delay;
    logic        last;
  } timer_result_t;

  timer_result_t awaited_words[$];

  // Shadow copy of the timer table.
  logic        tbl_valid [SLOTS];
  logic [62:0] tbl_exp   [SLOTS];
  logic [47:0] tbl_ivl   [SLOTS];
  logic [15:0] tbl_hnd   [SLOTS];
  logic [19:0] min_delay;

  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   idling_on = 1'b0;
  int   hold_cycles = 0;
  int   rx_gap = 0;
  logic [62:0] clock_us = 63'd1000;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic int earliest_slot();
    int best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && (best < 0 || tbl_exp[i] < tbl_exp[best])) best = i;
    return best;
  endfunction

  function automatic void queue_status(logic chg, logic full, logic [62:0] now);
    timer_result_t r;
    int e = earliest_slot();
    r = '{default: '0};
    r.changed = chg;
    r.full = full;
    r.last = 1'b1;
    if (e >= 0) begin
      r.pending = 1'b1;
      r.next_exp = tbl_exp[e];
      r.delay = (tbl_exp[e] > now) ? tbl_exp[e] - now : '0;
      if (r.delay < {43'd0, min_delay}) r.delay = {43'd0, min_delay};
    end
    awaited_words.push_back(r);
  endfunction

  // Works out the result words of one accepted word and updates the table.
  function automatic void predict_timer_word(logic kind, logic [62:0] now, logic [62:0] when,
                                             logic [47:0] ivl, logic [15:0] hnd);
    logic due [SLOTS];
    logic done [SLOTS];
    logic [63:0] sum;
    timer_result_t r;
    int free_slot = -1;
    int best;
    if (kind == KindAdd) begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!tbl_valid[i]) free_slot = i;
      if (free_slot < 0) begin
        queue_status(1'b0, 1'b1, now);
      end else begin
        best = earliest_slot();
        tbl_valid[free_slot] = 1'b1;
        tbl_exp[free_slot] = when;
        tbl_ivl[free_slot] = ivl;
        tbl_hnd[free_slot] = hnd;
        queue_status((best < 0) || (when < tbl_exp[best]), 1'b0, now);
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        due[i] = tbl_valid[i] && (tbl_exp[i] <= now);
        done[i] = 1'b0;
      end
      // Reports in expiration order, ties to the lower slot.
      forever begin
        best = -1;
        for (int i = 0; i < SLOTS; i++)
          if (due[i] && !done[i] && (best < 0 || tbl_exp[i] < tbl_exp[best])) best = i;
        if (best < 0) break;
        done[best] = 1'b1;
        r = '{default: '0};
        r.report = 1'b1;
        r.hnd = tbl_hnd[best];
        awaited_words.push_back(r);
      end
      // Free one-shot timers and re-arm periodic ones, saturating.
      for (int i = 0; i < SLOTS; i++) begin
        if (due[i]) begin
          if (tbl_ivl[i] == '0) begin
            tbl_valid[i] = 1'b0;
          end else begin
            sum = {1'b0, now} + {16'd0, tbl_ivl[i]};
            tbl_exp[i] = sum[63] ? TimeMax : sum[62:0];
          end
        end
      end
      queue_status(1'b0, 1'b0, now);
    end
  endfunction

  // Sends one word and predicts its results once it is accepted.
  task automatic send_word(logic kind, logic [62:0] now, logic [62:0] when,
                           logic [47:0] ivl, logic [15:0] hnd);
    if (idling_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_now_us = now;
    in_when_us = when;
    in_interval_us = ivl;
    in_handle = hnd;
    do @(posedge clk); while (!in_ready);
    predict_timer_word(kind, now, when, ivl, hnd);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic add_timer(logic [62:0] when, logic [47:0] ivl, logic [15:0] hnd);
    send_word(KindAdd, clock_us, when, ivl, hnd);
  endtask

  task automatic fire_expiry(logic [62:0] now);
    send_word(KindExpiry, now, rand63(), 48'({$urandom(), $urandom()}), 16'($urandom()));
  endtask

  task automatic wait_drained();
    while (awaited_words.size() != 0) @(negedge clk);
  endtask

  // The register is only written with the queue idle.
  task automatic write_min_delay(logic [19:0] value);
    wait_drained();
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    min_delay = value;
  endtask

  // A random word: timers near the running time, mostly one-shot, or expiries, now and then fully random.
  task automatic random_word();
    logic [62:0] when;
    logic [47:0] ivl;
    int pick = $urandom_range(0, 99);
    clock_us += $urandom_range(0, 400);
    if (pick < 4) begin
      send_word(1'($urandom_range(0, 1)), rand63(), rand63(),
                48'({$urandom(), $urandom()}), 16'($urandom()));
    end else if (pick < 55) begin
      when = ($urandom_range(0, 9) == 0) ? clock_us - $urandom_range(0, 500)
                                         : clock_us + $urandom_range(0, 3000);
      ivl = ($urandom_range(0, 15) == 0) ? 48'($urandom_range(1, 2000)) : '0;
      add_timer(when, ivl, 16'($urandom()));
    end else begin
      fire_expiry(clock_us + $urandom_range(0, 1500));
    end
  endtask

  // Result checker.
  function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_words.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        w = awaited_words.pop_front();
        check_field("is_expiry_report", w.report, out_is_expiry_report);
        check_field("expired_handle", w.hnd, out_expired_handle);
        check_field("earliest_changed", w.changed, out_earliest_changed);
        check_field("table_full", w.full, out_table_full);
        check_field("has_pending", w.pending, out_has_pending);
        check_field("next_expiration_us", w.next_exp, out_next_expiration_us);
        check_field("reload_delay_us", w.delay, out_reload_delay_us);
        check_field("last", w.last, out_last);
      end
    end
  end

  // Receiver: random stall bursts and the long hold-off.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_edges();
    fire_expiry('0);
    fire_expiry(TimeMax);
    add_timer(TimeMax, '0, 16'hFFFF);
    add_timer(63'd5000, '0, 16'h0000);
    add_timer(63'd5000, '0, 16'h1234);
    add_timer(63'd10, '0, 16'h00AA);
    add_timer(63'd20000, 48'hFFFF_FFFF_FFFF, 16'h5A5A);
    add_timer(63'd20000, 48'd1, 16'hA5A5);
    fire_expiry(63'd4999);
    fire_expiry(63'd5000);
    fire_expiry(63'd20000);
    fire_expiry(63'd20000);
    fire_expiry(63'd20001);
    fire_expiry(TimeMax - 63'd3);
    fire_expiry(TimeMax);
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) random_word();
  endtask

  task automatic test_config_sweep();
    write_min_delay(20'd0);
    test_random_traffic(25);
    write_min_delay(20'd1000000);
    test_random_traffic(25);
    write_min_delay(20'h7FFFF);
    test_random_traffic(25);
    write_min_delay(20'($urandom_range(0, 1000000)));
    test_random_traffic(25);
    write_min_delay(MinDelayReset);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    test_random_traffic(10);
    wait_drained();
    test_random_traffic(20);
  endtask

  // Fill every slot, hit the full table, then drain what is one-shot.
  task automatic test_full_table();
    for (int i = 0; i < SLOTS + 3; i++)
      add_timer(clock_us + $urandom_range(0, 200), ($urandom_range(0, 3) == 0) ?
                48'($urandom_range(1, 500)) : '0, 16'($urandom()));
    fire_expiry(clock_us + 300);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_kind = KindAdd;
    in_now_us = '0;
    in_when_us = '0;
    in_interval_us = '0;
    in_handle = '0;
    out_ready = 1'b0;
    min_delay = MinDelayReset;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_exp[i] = '0;
      tbl_ivl[i] = '0;
      tbl_hnd[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_edges();
    idling_on = 1'b1;
    test_random_traffic(100);
    test_backpressure();
    test_config_sweep();
    test_full_table();
    idling_on = 1'b0;
    test_random_traffic(60);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
